// File: rtl/crc8fr_pkg.sv
// types, constants and the crc-8 byte update for the crc-8 checked frame receiver
// no dependencies; used by crc8_checked_frame_receiver and crc8fr_checker

package crc8fr_pkg;

  // reflected dallas/maxim polynomial, initial value zero, no final xor
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // register index carried by paddr[2]
  localparam logic REG_SYNC = 1'b0;

  // frame_status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [3:0] {
    POS_SYNC   = 4'b0001,
    POS_OPCODE = 4'b0010,
    POS_INFO   = 4'b0100,
    POS_CHECK  = 4'b1000
  } frame_pos_e;

  // one byte through the lsb-first crc register, eight xor/shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crc8_checked_frame_receiver.sv
// crc-8 checked frame receiver: sync, opcode, info and check byte per frame
// depends on crc8fr_pkg
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------------
//  s_axis   | in        | tvalid / tready     | tdata[7:0] rx_byte
//  m_axis   | out       | tvalid / tready     | tdata[7:0] opcode, [15:8] info;
//           |           |                     | tuser frame_status
//  apb      | in        | psel/penable/pready | reg 0 at byte address 0: sync_byte
//
// one item a cycle unless a held result stalls the input: a byte goes into the input
// register, is checked against the frame position and the running crc once it leaves
// that register, and any result lands in the output register.
// the input register refills in the cycle it drains; a held result keeps the input
// register from draining, and so stalls the input side, while m_axis_tready is low.
// reset is asynchronous and clears the frame position, valids and sync_byte.

module crc8_checked_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] opcode, [15:8] info
  output logic        m_axis_tuser,   // [0] frame_status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  sync_sel;
  logic [7:0]            sync_byte_q;
  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  crc8fr_pkg::frame_pos_e pos_q, pos_d;
  logic [7:0]            op_q, op_d;
  logic [7:0]            info_q, info_d;
  logic [7:0]            crc_q, crc_d;
  logic                  out_vld_q, out_vld_d;
  logic                  out_status_q, out_status_d;
  logic [7:0]            out_op_q, out_op_d;
  logic [7:0]            out_info_q, out_info_d;
  logic                  step;
  logic                  emit;
  logic                  cfg_wr;

  // configuration port
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign sync_sel = (paddr[2] == crc8fr_pkg::REG_SYNC);
  assign prdata   = sync_sel ? {24'd0, sync_byte_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= 8'd0;
    end else if (cfg_wr && sync_sel) begin
      sync_byte_q <= pwdata[7:0];
    end
  end

  // input register
  assign step          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // frame position and result decision
  always_comb begin
    pos_d        = pos_q;
    op_d         = op_q;
    info_d       = info_q;
    crc_d        = crc_q;
    emit         = 1'b0;
    out_status_d = crc8fr_pkg::STATUS_REJECT;
    out_op_d     = 8'd0;
    out_info_d   = 8'd0;
    if (step) begin
      unique case (pos_q)
        crc8fr_pkg::POS_SYNC: begin
          if (in_byte_q != sync_byte_q) begin
            emit = 1'b1;
          end else begin
            pos_d = crc8fr_pkg::POS_OPCODE;
          end
        end
        crc8fr_pkg::POS_OPCODE: begin
          if (in_byte_q == 8'd0) begin
            emit  = 1'b1;
            pos_d = crc8fr_pkg::POS_SYNC;
          end else begin
            op_d  = in_byte_q;
            crc_d = crc8fr_pkg::crc8_update(crc8fr_pkg::CRC_INIT, in_byte_q);
            pos_d = crc8fr_pkg::POS_INFO;
          end
        end
        crc8fr_pkg::POS_INFO: begin
          info_d = in_byte_q;
          crc_d  = crc8fr_pkg::crc8_update(crc_q, in_byte_q);
          pos_d  = crc8fr_pkg::POS_CHECK;
        end
        crc8fr_pkg::POS_CHECK: begin
          emit  = 1'b1;
          pos_d = crc8fr_pkg::POS_SYNC;
          if (in_byte_q == crc_q) begin
            out_status_d = crc8fr_pkg::STATUS_OK;
            out_op_d     = op_q;
            out_info_d   = info_q;
          end
        end
        default: begin
          pos_d = crc8fr_pkg::POS_SYNC;
        end
      endcase
    end
  end

  assign out_vld_d = emit | (out_vld_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= crc8fr_pkg::POS_SYNC;
      out_vld_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    info_q <= info_d;
    crc_q  <= crc_d;
    if (emit) begin
      out_status_q <= out_status_d;
      out_op_q     <= out_op_d;
      out_info_q   <= out_info_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_info_q, out_op_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/crc8fr_checker.sv
// port-level checks on the crc-8 checked frame receiver, bound to the top level
// depends on crc8fr_pkg and crc8_checked_frame_receiver

module crc8fr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a held result keeps its payload until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result item valid during reset");

  // a rejected frame reports no opcode and no info
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == crc8fr_pkg::STATUS_REJECT) |-> m_axis_tdata == 16'd0)
    else $error("rejected item carries data");

  // a zero opcode never survives to an accepted frame
  a_ok_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == crc8fr_pkg::STATUS_OK) |-> m_axis_tdata[7:0] != 8'd0)
    else $error("accepted item with zero opcode");

  // no result can show up without an item having been taken earlier
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2) ||
      $past(m_axis_tvalid && m_axis_tready))
    else $error("result item without a source item");

endmodule

bind crc8_checked_frame_receiver crc8fr_checker u_crc8fr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
